/* rtl/core/xtpd_pkg.sv */
package xtpd_pkg;

  localparam int KW_COUNT    = 44;
  localparam int KW_MAX_LEN  = 18;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [4:0] {
    CL_QUOTE      = 5'd0,
    CL_EQUALS     = 5'd1,
    CL_SCRIPT     = 5'd2,
    CL_DTAG       = 5'd3,
    CL_HANDLER    = 5'd4,
    CL_JSSCHEME   = 5'd5,
    CL_DATASCHEME = 5'd6,
    CL_DFUNC      = 5'd7,
    CL_DOMOBJ     = 5'd8,
    CL_SINK       = 5'd9,
    CL_WORD       = 5'd10,
    CL_LT         = 5'd11,
    CL_GT         = 5'd12,
    CL_COMMENT    = 5'd13,
    CL_SLASH      = 5'd14,
    CL_POPEN      = 5'd15,
    CL_PCLOSE     = 5'd16,
    CL_DOT        = 5'd17,
    CL_COLON      = 5'd18,
    CL_OTHER      = 5'd19
  } tok_class_t;

  typedef enum logic [2:0] {
    KIND_OTHER  = 3'd0,
    KIND_WORD   = 3'd1,
    KIND_QUOTE  = 3'd2,
    KIND_EQUALS = 3'd3
  } tok_kind_t;

  // One entry per finished token, handed from classifier to detector.
  typedef struct packed {
    logic       restart;
    tok_class_t cls;
  } q_item_t;

  // Keyword text, right-aligned: byte i of a keyword of length L sits at
  // byte lane L-1-i counted from the LSB.
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "script",
    "iframe", "object", "embed", "svg", "math",
    "onload", "onerror", "onclick", "onmouseover", "onmouseenter",
    "onfocus", "onblur", "onsubmit", "onchange", "oninput", "onkeyup",
    "onkeydown",
    "javascript", "vbscript",
    "data",
    "alert", "eval", "prompt", "confirm", "settimeout", "setinterval",
    "function",
    "document", "window", "location", "self", "top", "parent",
    "cookie", "write", "writeln", "innerhtml", "outerhtml",
    "insertadjacenthtml", "href", "src", "assign", "replace"
  };

  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd6,
    5'd6, 5'd6, 5'd5, 5'd3, 5'd4,
    5'd6, 5'd7, 5'd7, 5'd11, 5'd12,
    5'd7, 5'd6, 5'd8, 5'd8, 5'd7, 5'd7,
    5'd9,
    5'd10, 5'd8,
    5'd4,
    5'd5, 5'd4, 5'd6, 5'd7, 5'd10, 5'd11,
    5'd8,
    5'd8, 5'd6, 5'd8, 5'd4, 5'd3, 5'd6,
    5'd6, 5'd5, 5'd7, 5'd9, 5'd9,
    5'd18, 5'd4, 5'd3, 5'd6, 5'd7
  };

  localparam tok_class_t KW_CLASS [KW_COUNT] = '{
    CL_SCRIPT,
    CL_DTAG, CL_DTAG, CL_DTAG, CL_DTAG, CL_DTAG,
    CL_HANDLER, CL_HANDLER, CL_HANDLER, CL_HANDLER, CL_HANDLER,
    CL_HANDLER, CL_HANDLER, CL_HANDLER, CL_HANDLER, CL_HANDLER, CL_HANDLER,
    CL_HANDLER,
    CL_JSSCHEME, CL_JSSCHEME,
    CL_DATASCHEME,
    CL_DFUNC, CL_DFUNC, CL_DFUNC, CL_DFUNC, CL_DFUNC, CL_DFUNC,
    CL_DFUNC,
    CL_DOMOBJ, CL_DOMOBJ, CL_DOMOBJ, CL_DOMOBJ, CL_DOMOBJ, CL_DOMOBJ,
    CL_SINK, CL_SINK, CL_SINK, CL_SINK, CL_SINK,
    CL_SINK, CL_SINK, CL_SINK, CL_SINK, CL_SINK
  };

  // Byte of keyword k at position pos; zero past the keyword's end.
  function automatic logic [7:0] kw_byte(input int k, input logic [4:0] pos);
    logic [KW_MAX_LEN*8-1:0] t;
    int sh;
    t  = KW_TEXT[k];
    sh = (int'(KW_LEN[k]) - 1 - int'(pos)) * 8;
    if (pos < KW_LEN[k]) begin
      return t[sh +: 8];
    end
    return 8'h00;
  endfunction

endpackage

/* rtl/core/xtpd_tok_if.sv */
interface xtpd_tok_if;
  logic       valid;
  logic       ready;
  logic       new_stream;
  logic [2:0] token_kind;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, new_stream, token_kind, char_code, last_char,
                  input ready);
  modport sink   (input valid, new_stream, token_kind, char_code, last_char,
                  output ready);
endinterface

/* rtl/core/xtpd_res_if.sv */
interface xtpd_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_class;
  logic       detected;

  modport source (output valid, token_class, detected, input ready);
  modport sink   (input valid, token_class, detected, output ready);
endinterface

/* rtl/core/xtpd_front.sv */
module xtpd_front (
  input  logic               clk,
  input  logic               rst,
  xtpd_tok_if.sink           tok,
  output logic               push,
  output xtpd_pkg::q_item_t  push_item,
  input  logic               full
);

  logic [xtpd_pkg::KW_COUNT-1:0] cands;
  logic [4:0]                    pos;
  logic [7:0]                    first_byte;
  logic [7:0]                    second_byte;
  logic                          pend_restart;

  logic [xtpd_pkg::KW_COUNT-1:0] eff_cands;
  logic [xtpd_pkg::KW_COUNT-1:0] cands_next;
  logic [4:0]                    eff_pos;
  logic [7:0]                    first_next;
  logic [7:0]                    second_next;
  logic [7:0]                    lc;
  logic [5:0]                    len;
  logic                          restart_next;
  xtpd_pkg::tok_class_t          word_cls;
  xtpd_pkg::tok_class_t          byte_cls;
  xtpd_pkg::tok_class_t          cls;
  logic                          xfer;

  assign tok.ready = !full;
  assign xfer      = tok.valid && tok.ready;

  assign lc = (tok.char_code >= 8'h41 && tok.char_code <= 8'h5A) ?
              tok.char_code + 8'h20 : tok.char_code;

  // A new stream drops the token assembled so far before this byte.
  assign eff_cands = tok.new_stream ? '1 : cands;
  assign eff_pos   = tok.new_stream ? 5'd0 : pos;

  always_comb begin
    for (int k = 0; k < xtpd_pkg::KW_COUNT; k++) begin
      cands_next[k] = eff_cands[k] && (eff_pos < xtpd_pkg::KW_LEN[k]) &&
                      (xtpd_pkg::kw_byte(k, eff_pos) == lc);
    end
  end

  always_comb begin
    first_next  = tok.new_stream ? 8'h00 : first_byte;
    second_next = tok.new_stream ? 8'h00 : second_byte;
    if (eff_pos == 5'd0) first_next = tok.char_code;
    if (eff_pos == 5'd1) second_next = tok.char_code;
  end

  assign len          = {1'b0, eff_pos} + 6'd1;
  assign restart_next = pend_restart || tok.new_stream;

  // Lowest keyword index wins; scan from the top down.
  always_comb begin
    word_cls = xtpd_pkg::CL_WORD;
    for (int k = xtpd_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (cands_next[k] && ({1'b0, xtpd_pkg::KW_LEN[k]} == len)) begin
        word_cls = xtpd_pkg::KW_CLASS[k];
      end
    end
  end

  always_comb begin
    case (first_next)
      8'h3C: byte_cls = xtpd_pkg::CL_LT;
      8'h3E: byte_cls = xtpd_pkg::CL_GT;
      8'h2F: byte_cls = (len >= 6'd2 && second_next == 8'h2A) ?
                        xtpd_pkg::CL_COMMENT : xtpd_pkg::CL_SLASH;
      8'h28: byte_cls = xtpd_pkg::CL_POPEN;
      8'h29: byte_cls = xtpd_pkg::CL_PCLOSE;
      8'h2E: byte_cls = xtpd_pkg::CL_DOT;
      8'h3A: byte_cls = xtpd_pkg::CL_COLON;
      default: byte_cls = xtpd_pkg::CL_OTHER;
    endcase
  end

  always_comb begin
    case (tok.token_kind)
      xtpd_pkg::KIND_OTHER:  cls = byte_cls;
      xtpd_pkg::KIND_WORD:   cls = word_cls;
      xtpd_pkg::KIND_QUOTE:  cls = xtpd_pkg::CL_QUOTE;
      xtpd_pkg::KIND_EQUALS: cls = xtpd_pkg::CL_EQUALS;
      default:               cls = xtpd_pkg::CL_OTHER;
    endcase
  end

  assign push              = xfer && tok.last_char;
  assign push_item.restart = restart_next;
  assign push_item.cls     = cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      cands        <= '1;
      pos          <= 5'd0;
      first_byte   <= 8'h00;
      second_byte  <= 8'h00;
      pend_restart <= 1'b0;
    end else if (xfer) begin
      if (tok.last_char) begin
        cands        <= '1;
        pos          <= 5'd0;
        first_byte   <= 8'h00;
        second_byte  <= 8'h00;
        pend_restart <= 1'b0;
      end else begin
        cands        <= cands_next;
        pos          <= (eff_pos == 5'd31) ? eff_pos : eff_pos + 5'd1;
        first_byte   <= first_next;
        second_byte  <= second_next;
        pend_restart <= restart_next;
      end
    end
  end

endmodule

/* rtl/core/xtpd_queue.sv */
module xtpd_queue #(
  parameter int DEPTH = xtpd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  xtpd_pkg::q_item_t  push_item,
  output logic               full,
  input  logic               pop,
  output logic               avail,
  output xtpd_pkg::q_item_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xtpd_pkg::q_item_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CW'(DEPTH));
  assign avail   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/xtpd_back.sv */
module xtpd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  xtpd_pkg::q_item_t  head,
  output logic               pop,
  xtpd_res_if.source         res
);

  typedef enum logic [12:0] {
    S_START   = 13'b0000000000001,
    S_LT      = 13'b0000000000010,
    S_HTML    = 13'b0000000000100,
    S_DTAG    = 13'b0000000001000,
    S_HANDLER = 13'b0000000010000,
    S_ATTREQ  = 13'b0000000100000,
    S_JS      = 13'b0000001000000,
    S_DATA    = 13'b0000010000000,
    S_DFUNC   = 13'b0000100000000,
    S_DOMOBJ  = 13'b0001000000000,
    S_DOT     = 13'b0010000000000,
    S_SINK    = 13'b0100000000000,
    S_ACCEPT  = 13'b1000000000000
  } det_state_t;

  det_state_t state;
  det_state_t base;
  det_state_t state_next;
  xtpd_pkg::tok_class_t c;

  assign c    = head.cls;
  assign base = head.restart ? S_START : state;
  assign pop  = avail && (!res.valid || res.ready);

  always_comb begin
    case (base)
      S_START: begin
        case (c)
          xtpd_pkg::CL_LT:         state_next = S_LT;
          xtpd_pkg::CL_HANDLER:    state_next = S_HANDLER;
          xtpd_pkg::CL_JSSCHEME:   state_next = S_JS;
          xtpd_pkg::CL_DATASCHEME: state_next = S_DATA;
          xtpd_pkg::CL_DFUNC:      state_next = S_DFUNC;
          xtpd_pkg::CL_DOMOBJ:     state_next = S_DOMOBJ;
          default:                 state_next = S_START;
        endcase
      end
      S_LT: begin
        case (c)
          xtpd_pkg::CL_SCRIPT: state_next = S_ACCEPT;
          xtpd_pkg::CL_DTAG:   state_next = S_DTAG;
          xtpd_pkg::CL_WORD:   state_next = S_HTML;
          default:             state_next = S_START;
        endcase
      end
      S_HTML, S_DTAG: begin
        case (c)
          xtpd_pkg::CL_HANDLER:    state_next = S_HANDLER;
          xtpd_pkg::CL_JSSCHEME:   state_next = S_JS;
          xtpd_pkg::CL_DATASCHEME: state_next = S_DATA;
          xtpd_pkg::CL_GT:         state_next = (base == S_DTAG) ? S_ACCEPT : S_START;
          default:                 state_next = base;
        endcase
      end
      S_HANDLER:
        state_next = (c == xtpd_pkg::CL_EQUALS) ? S_ATTREQ : S_START;
      S_ATTREQ:
        state_next = (c == xtpd_pkg::CL_QUOTE || c == xtpd_pkg::CL_WORD ||
                      c == xtpd_pkg::CL_DFUNC || c == xtpd_pkg::CL_JSSCHEME) ?
                     S_ACCEPT : S_START;
      S_JS:
        state_next = (c == xtpd_pkg::CL_COLON || c == xtpd_pkg::CL_DFUNC) ?
                     S_ACCEPT : S_START;
      S_DATA:
        state_next = (c == xtpd_pkg::CL_COLON) ? S_ACCEPT : S_START;
      S_DFUNC:
        state_next = (c == xtpd_pkg::CL_POPEN) ? S_ACCEPT : S_START;
      S_DOMOBJ:
        state_next = (c == xtpd_pkg::CL_DOT) ? S_DOT : S_START;
      S_DOT:
        state_next = (c == xtpd_pkg::CL_SINK) ? S_SINK : S_START;
      S_SINK:
        state_next = (c == xtpd_pkg::CL_EQUALS || c == xtpd_pkg::CL_POPEN) ?
                     S_ACCEPT : S_START;
      S_ACCEPT:
        state_next = S_ACCEPT;
      default:
        state_next = S_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_START;
      res.valid <= 1'b0;
    end else begin
      if (pop) begin
        state     <= state_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.token_class <= c;
      res.detected    <= (state_next == S_ACCEPT);
    end
  end

endmodule

/* rtl/core/xss_token_pattern_detector.sv */
// Channel | Dir | Payload                                        | Transfer
// tok     | in  | new_stream, token_kind, char_code, last_char   | valid && ready
// res     | out | token_class, detected                          | valid && ready
//
// One byte per cycle while tok.ready is high; each token's last byte yields one
// result (classify and queue, then detector step into the output register).
// The rate is set by the per-byte parallel keyword compare in the classifier.
// Synchronous reset clears token assembly, queue pointers, detector state and res.valid.
// A stalled result holds in the output register; the queue absorbs the next
// tokens, and tok.ready drops only once the queue is full.
module xss_token_pattern_detector #(
  parameter int QUEUE_DEPTH = xtpd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  xtpd_tok_if.sink   tok,
  xtpd_res_if.source res
);

  logic              push;
  logic              full;
  logic              pop;
  logic              avail;
  xtpd_pkg::q_item_t push_item;
  xtpd_pkg::q_item_t head;

  xtpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  xtpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  xtpd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .head  (head),
    .pop   (pop),
    .res   (res)
  );

endmodule
